FILE: rtl/ste_pkg.sv
// shared types, constants and helpers for the sprite tile expander
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ste_pkg;

  // attribute word bit positions
  localparam int ATTR_FLIP_X  = 0;
  localparam int ATTR_FLIP_Y  = 1;
  localparam int ATTR_ENABLE  = 2;
  localparam int ATTR_PRIO    = 5;
  localparam int ATTR_FLICKER = 6;

  // color/size word fields
  localparam int CSW_PAL_LO  = 4;
  localparam int CSW_PAL_HI  = 7;
  localparam int CSW_SIZE_LO = 0;
  localparam int CSW_SIZE_HI = 1;

  // field widths
  localparam int WORD_W   = 16;
  localparam int PAL_W    = 4;
  localparam int SCROLL_W = 9;
  localparam int TX_W     = 18;
  localparam int TY_W     = 17;
  localparam int SLOG_W   = 2;
  localparam int POS_W    = 3;
  localparam int OFS_W    = 6;

  // queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one drawable sprite, as handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] tile_base;
    logic [PAL_W-1:0]  palette;
    logic [TX_W-1:0]   x_start;
    logic [WORD_W-1:0] y_start;
    logic              mirror_x;
    logic              mirror_y;
    logic [SLOG_W-1:0] size_log;
  } sprite_desc_t;

  // queue occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // bit-interleaved tile offset: col0,row0,col1,row1,col2,row2
  function automatic logic [OFS_W-1:0] interleave(input logic [POS_W-1:0] col,
                                                  input logic [POS_W-1:0] row);
    interleave = {row[2], col[2], row[1], col[1], row[0], col[0]};
  endfunction

endpackage

FILE: rtl/sprite_tile_expander.sv
// Sprite tile expander. Each accepted sprite beat is tested against enable,
// flicker/frame parity and the priority pass; a sprite that is drawn becomes
// size*size tile beats (1, 4, 16 or 64), rows outer and columns inner, one
// beat per clock from the back-end tile counter while the sink does not
// stall. A sprite that is not drawn is never queued and produces nothing;
// like any sprite beat it is held while the queue is full. A two-entry queue
// lets the front take sprites while the back is still expanding earlier
// ones. The scroll register is written through the cfg channel, which is
// always ready; write it only while the block is idle.
// Depends on ste_pkg, ste_front, ste_queue and ste_back.
`timescale 1ns / 1ps

module sprite_tile_expander import ste_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic signed [SCROLL_W-1:0] scroll_offset,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [WORD_W-1:0]          attr_word,
  input  logic [WORD_W-1:0]          tile_base,
  input  logic [WORD_W-1:0]          color_size_word,
  input  logic [WORD_W-1:0]          y_pos,
  input  logic [WORD_W-1:0]          x_pos,
  input  logic                       frame_odd,
  input  logic                       priority_pass,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [WORD_W-1:0]          tile_code,
  output logic [PAL_W-1:0]           palette,
  output logic signed [TX_W-1:0]     tile_x,
  output logic [TY_W-1:0]            tile_y,
  output logic                       mirror_x,
  output logic                       mirror_y,
  output logic                       last
);

  queue_status_t qstat;
  logic          push;
  logic          pop;
  sprite_desc_t  push_desc;
  sprite_desc_t  head;

  // classify and build descriptors
  ste_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .scroll_offset   (scroll_offset),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .attr_word       (attr_word),
    .tile_base       (tile_base),
    .color_size_word (color_size_word),
    .y_pos           (y_pos),
    .x_pos           (x_pos),
    .frame_odd       (frame_odd),
    .priority_pass   (priority_pass),
    .qstat           (qstat),
    .push            (push),
    .push_desc       (push_desc)
  );

  // decoupling queue
  ste_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // tile expansion
  ste_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tile_code (tile_code),
    .palette   (palette),
    .tile_x    (tile_x),
    .tile_y    (tile_y),
    .mirror_x  (mirror_x),
    .mirror_y  (mirror_y),
    .last      (last)
  );

endmodule

FILE: rtl/ste_front.sv
// front end: accepts sprite beats, holds the scroll register, drops sprites
// not drawn this pass and builds a descriptor for the queue; uses ste_pkg
`timescale 1ns / 1ps

module ste_front import ste_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic signed [SCROLL_W-1:0] scroll_offset,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [WORD_W-1:0]          attr_word,
  input  logic [WORD_W-1:0]          tile_base,
  input  logic [WORD_W-1:0]          color_size_word,
  input  logic [WORD_W-1:0]          y_pos,
  input  logic [WORD_W-1:0]          x_pos,
  input  logic                       frame_odd,
  input  logic                       priority_pass,
  input  queue_status_t              qstat,
  output logic                       push,
  output sprite_desc_t               push_desc
);

  logic signed [SCROLL_W-1:0] scroll;
  logic                       drawn;

  // scroll register, always ready for a write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll <= '0;
    end else if (cfg_valid) begin
      scroll <= scroll_offset;
    end
  end

  // hold the source while the queue has no room
  assign in_stall = qstat.full;

  // draw test: enabled, flicker only on odd frames, priority matches pass
  assign drawn = attr_word[ATTR_ENABLE]
              && (!attr_word[ATTR_FLICKER] || frame_odd)
              && (attr_word[ATTR_PRIO] == priority_pass);

  assign push = in_valid && !qstat.full && drawn;

  // descriptor build, x already offset by scroll
  always_comb begin
    push_desc.tile_base = tile_base;
    push_desc.palette   = color_size_word[CSW_PAL_HI:CSW_PAL_LO];
    push_desc.x_start   = TX_W'({2'b00, x_pos}) + TX_W'(signed'(scroll));
    push_desc.y_start   = y_pos;
    push_desc.mirror_x  = attr_word[ATTR_FLIP_X];
    push_desc.mirror_y  = attr_word[ATTR_FLIP_Y];
    push_desc.size_log  = color_size_word[CSW_SIZE_HI:CSW_SIZE_LO];
  end

endmodule

FILE: rtl/ste_queue.sv
// short descriptor queue between front and back ends
// uses ste_pkg for the descriptor type and depth
`timescale 1ns / 1ps

module ste_queue import ste_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sprite_desc_t  push_desc,
  input  logic          pop,
  output sprite_desc_t  head,
  output queue_status_t qstat
);

  sprite_desc_t      mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign head        = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/ste_back.sv
// back end: walks the tiles of the queue head, rows outer, columns inner,
// into an output register; uses ste_pkg
`timescale 1ns / 1ps

module ste_back import ste_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  sprite_desc_t           head,
  input  queue_status_t          qstat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [WORD_W-1:0]      tile_code,
  output logic [PAL_W-1:0]       palette,
  output logic signed [TX_W-1:0] tile_x,
  output logic [TY_W-1:0]        tile_y,
  output logic                   mirror_x,
  output logic                   mirror_y,
  output logic                   last
);

  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;
  logic [POS_W-1:0] size_m1;
  logic [POS_W-1:0] cpos;
  logic [POS_W-1:0] rpos;
  logic             load;
  logic             tile_last;
  logic             col_end;

  // tile position within the sprite, mirrored under flip
  assign size_m1   = POS_W'((4'd1 << head.size_log) - 4'd1);
  assign cpos      = head.mirror_x ? (size_m1 - col) : col;
  assign rpos      = head.mirror_y ? (size_m1 - row) : row;
  assign col_end   = (col == size_m1);
  assign tile_last = col_end && (row == size_m1);

  // issue a beat when a sprite waits and the output register is free
  assign load = !qstat.empty && (!out_valid || !out_stall);
  assign pop  = load && tile_last;

  // row and column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (load) begin
      if (tile_last) begin
        row <= '0;
        col <= '0;
      end else if (col_end) begin
        row <= row + 1'b1;
        col <= '0;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      tile_code <= head.tile_base + WORD_W'(interleave(col, row));
      palette   <= head.palette;
      tile_x    <= signed'(head.x_start + TX_W'({cpos, 3'b000}));
      tile_y    <= TY_W'({1'b0, head.y_start}) + TY_W'({rpos, 3'b000});
      mirror_x  <= head.mirror_x;
      mirror_y  <= head.mirror_y;
      last      <= tile_last;
    end
  end

endmodule

FILE: sim/tb_sprite_tile_expander.sv
// self-checking testbench for sprite_tile_expander: directed and random sprites,
// each expanded into expected tile beats by a local model and checked in order
// depends on ste_pkg and the sprite_tile_expander rtl
`timescale 1ns / 1ps

module tb_sprite_tile_expander;
  import ste_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int REPORT_LIMIT   = 10;
  localparam int SCROLL_MIN     = -251;
  localparam int SCROLL_MAX     = 4;

  typedef struct {
    logic [WORD_W-1:0] attr;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] csw;
    logic [WORD_W-1:0] ypos;
    logic [WORD_W-1:0] xpos;
    logic              odd;
    logic              pass;
  } sprite_t;

  typedef struct {
    logic [WORD_W-1:0]    code;
    logic [PAL_W-1:0]     pal;
    logic [TX_W-1:0]      tx;
    logic [TY_W-1:0]      ty;
    logic                 mx;
    logic                 my;
    logic                 fin;
  } tile_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic signed [SCROLL_W-1:0] scroll_offset;
  logic                       in_valid;
  logic                       in_stall;
  logic [WORD_W-1:0]          attr_word;
  logic [WORD_W-1:0]          tile_base;
  logic [WORD_W-1:0]          color_size_word;
  logic [WORD_W-1:0]          y_pos;
  logic [WORD_W-1:0]          x_pos;
  logic                       frame_odd;
  logic                       priority_pass;
  logic                       out_valid;
  logic                       out_stall;
  logic [WORD_W-1:0]          tile_code;
  logic [PAL_W-1:0]           palette;
  logic signed [TX_W-1:0]     tile_x;
  logic [TY_W-1:0]            tile_y;
  logic                       mirror_x;
  logic                       mirror_y;
  logic                       last;

  // model state and bookkeeping
  logic signed [SCROLL_W-1:0] scroll_now;
  tile_t                      pending_tiles[$];
  int                         send_idle_pct;
  int                         recv_idle_pct;
  int                         mismatches;
  int                         sprites_sent;
  int                         sprites_drawn;
  int                         tiles_checked;
  int                         scroll_writes;
  int                         idle_cycles;

  sprite_tile_expander dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .scroll_offset(scroll_offset),
    .in_valid(in_valid), .in_stall(in_stall),
    .attr_word(attr_word), .tile_base(tile_base), .color_size_word(color_size_word),
    .y_pos(y_pos), .x_pos(x_pos), .frame_odd(frame_odd), .priority_pass(priority_pass),
    .out_valid(out_valid), .out_stall(out_stall),
    .tile_code(tile_code), .palette(palette), .tile_x(tile_x), .tile_y(tile_y),
    .mirror_x(mirror_x), .mirror_y(mirror_y), .last(last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic logic [OFS_W-1:0] tile_offset(input int col, input int row);
    logic [OFS_W-1:0] v;
    v = '0;
    for (int i = 0; i < POS_W; i++) begin
      v[2*i]   = col[i];
      v[2*i+1] = row[i];
    end
    return v;
  endfunction

  function automatic bit sprite_visible(input sprite_t s);
    if (!s.attr[ATTR_ENABLE]) return 1'b0;
    if (s.attr[ATTR_FLICKER] && !s.odd) return 1'b0;
    return s.attr[ATTR_PRIO] == s.pass;
  endfunction

  // queue the tile beats that one sprite should produce
  task automatic expand_sprite(input sprite_t s);
    int    side;
    int    cpos;
    int    rpos;
    int    xv;
    int    yv;
    tile_t t;
    if (!sprite_visible(s)) return;
    sprites_drawn++;
    side = 1 << s.csw[CSW_SIZE_HI:CSW_SIZE_LO];
    for (int r = 0; r < side; r++) begin
      for (int c = 0; c < side; c++) begin
        cpos   = s.attr[ATTR_FLIP_X] ? side - 1 - c : c;
        rpos   = s.attr[ATTR_FLIP_Y] ? side - 1 - r : r;
        xv     = int'(s.xpos) + int'(scroll_now) + 8 * cpos;
        yv     = int'(s.ypos) + 8 * rpos;
        t.code = s.base + WORD_W'(tile_offset(c, r));
        t.pal  = s.csw[CSW_PAL_HI:CSW_PAL_LO];
        t.tx   = xv[TX_W-1:0];
        t.ty   = yv[TY_W-1:0];
        t.mx   = s.attr[ATTR_FLIP_X];
        t.my   = s.attr[ATTR_FLIP_Y];
        t.fin  = (r == side - 1) && (c == side - 1);
        pending_tiles.push_back(t);
      end
    end
  endtask

  // ---------------------------------------------------------------- helpers

  function automatic logic [WORD_W-1:0] attr_of(input bit fx, input bit fy, input bit en,
                                                input bit prio, input bit flick);
    logic [WORD_W-1:0] a;
    a = '0;
    a[ATTR_FLIP_X]  = fx;
    a[ATTR_FLIP_Y]  = fy;
    a[ATTR_ENABLE]  = en;
    a[ATTR_PRIO]    = prio;
    a[ATTR_FLICKER] = flick;
    return a;
  endfunction

  function automatic logic [WORD_W-1:0] csw_of(input int pal, input int slog);
    logic [WORD_W-1:0] w;
    w = '0;
    w[CSW_PAL_HI:CSW_PAL_LO]   = PAL_W'(pal);
    w[CSW_SIZE_HI:CSW_SIZE_LO] = SLOG_W'(slog);
    return w;
  endfunction

  function automatic sprite_t mk_sprite(input logic [WORD_W-1:0] attr,
                                        input logic [WORD_W-1:0] base,
                                        input logic [WORD_W-1:0] csw,
                                        input logic [WORD_W-1:0] ypos,
                                        input logic [WORD_W-1:0] xpos,
                                        input bit odd, input bit pass);
    sprite_t s;
    s.attr = attr; s.base = base; s.csw = csw;
    s.ypos = ypos; s.xpos = xpos; s.odd = odd; s.pass = pass;
    return s;
  endfunction

  // random sprite, well formed when asked, with a bias towards small sizes
  function automatic sprite_t random_sprite(input bit well_formed);
    sprite_t s;
    int      pick;
    s.attr = WORD_W'($urandom_range(16'hFFFF));
    s.base = WORD_W'($urandom_range(16'hFFFF));
    s.csw  = WORD_W'($urandom_range(16'hFFFF));
    s.ypos = WORD_W'($urandom_range(16'hFFFF));
    s.xpos = WORD_W'($urandom_range(16'hFFFF));
    s.odd  = 1'($urandom_range(1));
    s.pass = 1'($urandom_range(1));
    pick   = $urandom_range(99);
    s.csw[CSW_SIZE_HI:CSW_SIZE_LO] =
      SLOG_W'((pick < 35) ? 0 : (pick < 65) ? 1 : (pick < 90) ? 2 : 3);
    if (well_formed) begin
      s.attr[ATTR_ENABLE] = 1'b1;
      s.attr[ATTR_PRIO]   = s.pass;
      if (s.attr[ATTR_FLICKER]) s.odd = 1'b1;
    end
    return s;
  endfunction

  // one sprite beat, with a random gap in front of it
  task automatic send_sprite(input sprite_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    attr_word       <= s.attr;
    tile_base       <= s.base;
    color_size_word <= s.csw;
    y_pos           <= s.ypos;
    x_pos           <= s.xpos;
    frame_odd       <= s.odd;
    priority_pass   <= s.pass;
    do @(posedge clk); while (in_stall);
    sprites_sent++;
    expand_sprite(s);
  endtask

  // hold off the sender until every queued tile has been seen
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_scroll(input int value);
    wait_drain();
    cfg_valid     <= 1'b1;
    scroll_offset <= SCROLL_W'(value);
    do @(posedge clk); while (!cfg_ready);
    scroll_now = SCROLL_W'(value);
    scroll_writes++;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_tile_sizes();
    for (int slog = 0; slog < 4; slog++)
      send_sprite(mk_sprite(attr_of(0, 0, 1, 0, 0), WORD_W'(16'h0100 * slog),
                            csw_of(slog + 3, slog), WORD_W'(40 + slog), WORD_W'(80 + slog),
                            1'b0, 1'b0));
  endtask

  task automatic test_mirroring();
    for (int f = 0; f < 4; f++)
      send_sprite(mk_sprite(attr_of(f[0], f[1], 1, 1, 0), 16'h2000, csw_of(9, (f == 3) ? 3 : 2),
                            16'd100, 16'd200, 1'b1, 1'b1));
  endtask

  task automatic test_draw_gating();
    // disabled sprite, flicker on an even frame and on an odd one, priority pass mismatch both ways
    send_sprite(mk_sprite(attr_of(1, 1, 0, 0, 0), 16'h0010, csw_of(1, 1), 16'd8, 16'd8, 1, 0));
    send_sprite(mk_sprite(attr_of(0, 0, 1, 0, 1), 16'h0020, csw_of(2, 1), 16'd8, 16'd8, 0, 0));
    send_sprite(mk_sprite(attr_of(0, 0, 1, 0, 1), 16'h0030, csw_of(3, 1), 16'd8, 16'd8, 1, 0));
    send_sprite(mk_sprite(attr_of(0, 0, 1, 1, 0), 16'h0040, csw_of(4, 0), 16'd8, 16'd8, 0, 0));
    send_sprite(mk_sprite(attr_of(0, 0, 1, 0, 0), 16'h0050, csw_of(5, 0), 16'd8, 16'd8, 0, 1));
  endtask

  task automatic test_field_extremes();
    // everything high: tile code wraps past 16 bits, positions at the top
    send_sprite(mk_sprite(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_sprite(mk_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0));
    send_sprite(mk_sprite(attr_of(0, 0, 1, 0, 0), 16'hFFF0, csw_of(15, 2), 16'hFFFF,
                          16'hFFFF, 1'b0, 1'b0));
    send_sprite(mk_sprite(attr_of(1, 0, 1, 0, 0), 16'h0000, csw_of(0, 1), 16'h0000,
                          16'h0000, 1'b0, 1'b0));
  endtask

  task automatic test_scroll_extremes();
    set_scroll(SCROLL_MIN);
    send_sprite(mk_sprite(attr_of(0, 0, 1, 0, 0), 16'h0300, csw_of(6, 1), 16'd0, 16'd0, 0, 0));
    send_sprite(mk_sprite(attr_of(1, 0, 1, 0, 0), 16'h0310, csw_of(7, 1), 16'd5, 16'hFFFF, 0, 0));
    set_scroll(SCROLL_MAX);
    send_sprite(mk_sprite(attr_of(0, 1, 1, 0, 0), 16'h0320, csw_of(8, 1), 16'd0, 16'hFFFF, 0, 0));
    send_sprite(mk_sprite(attr_of(0, 0, 1, 0, 0), 16'h0330, csw_of(9, 0), 16'd3, 16'd0, 0, 0));
  endtask

  task automatic test_random_traffic(input int drawn_target, input int s_pct, input int r_pct);
    int start_drawn;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    set_scroll($urandom_range(SCROLL_MAX - SCROLL_MIN) + SCROLL_MIN);
    start_drawn = sprites_drawn;
    while (sprites_drawn - start_drawn < drawn_target) begin
      send_sprite(random_sprite($urandom_range(99) < 80));
      // pause to drain half way through, once more for each undrawn sprite at that point
      if (sprites_drawn - start_drawn == drawn_target / 2) wait_drain();
    end
  endtask

  // ---------------------------------------------------------------- sink side

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each tile beat with the oldest queued tile
  always @(posedge clk) begin
    tile_t want;
    if (!rst && out_valid && !out_stall) begin
      tiles_checked++;
      if (pending_tiles.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected tile beat: code %h x %0d y %0d", tile_code, tile_x, tile_y);
      end else begin
        want = pending_tiles.pop_front();
        if (tile_code !== want.code || palette !== want.pal || tile_x !== want.tx ||
            tile_y !== want.ty || mirror_x !== want.mx || mirror_y !== want.my ||
            last !== want.fin) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"tile mismatch: exp code %h pal %h x %h y %h mx %b my %b last %b",
                      " / got code %h pal %h x %h y %h mx %b my %b last %b"},
                     want.code, want.pal, want.tx, want.ty, want.mx, want.my, want.fin,
                     tile_code, palette, tile_x, tile_y, mirror_x, mirror_y, last);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d tiles outstanding", pending_tiles.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    scroll_offset   = '0;
    in_valid        = 1'b0;
    attr_word       = '0;
    tile_base       = '0;
    color_size_word = '0;
    y_pos           = '0;
    x_pos           = '0;
    frame_odd       = 1'b0;
    priority_pass   = 1'b0;
    out_stall       = 1'b0;
    scroll_now      = '0;
    send_idle_pct   = 24;
    recv_idle_pct   = 60;
    mismatches      = 0;
    sprites_sent    = 0;
    sprites_drawn   = 0;
    tiles_checked   = 0;
    scroll_writes   = 0;
    idle_cycles     = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // scroll left at its reset value for the first directed sprites
    test_tile_sizes();
    test_mirroring();
    test_draw_gating();
    test_field_extremes();
    test_scroll_extremes();
    set_scroll(0);

    test_random_traffic(30, 24, 60);
    test_random_traffic(30, 60, 24);
    test_random_traffic(30, 0, 0);

    wait_drain();
    mismatches += pending_tiles.size();
    $display("sprites sent %0d (drawn %0d), tile beats checked %0d, scroll writes %0d",
             sprites_sent, sprites_drawn, tiles_checked, scroll_writes);
    $display("mismatches %0d", mismatches);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/ste_pkg.sv
rtl/ste_front.sv
rtl/ste_queue.sv
rtl/ste_back.sv
rtl/sprite_tile_expander.sv
sim/tb_sprite_tile_expander.sv
